### hw/rtl/gmps_pkg.sv
`default_nettype none

package gmps_pkg;

  // cell index space fixed by the 6-bit cell fields
  localparam int unsigned CellW   = 6;
  localparam int unsigned NumCells = 64;
  localparam int unsigned DimW    = 4;
  localparam int unsigned DepthW  = 7;
  localparam int unsigned DirW    = 3;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRowsInUse = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgColsInUse = 2'd1;

  // search directions, in ascending neighbour index order
  localparam logic [DirW-1:0] DirUp    = 3'd0;
  localparam logic [DirW-1:0] DirLeft  = 3'd1;
  localparam logic [DirW-1:0] DirRight = 3'd2;
  localparam logic [DirW-1:0] DirDown  = 3'd3;
  localparam logic [DirW-1:0] DirDone  = 3'd4;

  localparam logic       FuncWall  = 1'b0;
  localparam logic       FuncSolve = 1'b1;

  typedef struct packed {
    logic             func;
    logic [CellW-1:0] cell_a;
    logic [CellW-1:0] cell_b;
  } in_item_t;

  typedef struct packed {
    logic [CellW-1:0] path_cell;
    logic             found;
    logic             last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic rem_step;
    logic wall_write;
    logic search_init;
    logic push;
    logic next_dir;
    logic pop;
    logic load_top;
    logic emit_init;
    logic emit_rd;
    logic emit_load;
    logic emit_nopath;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rem_lt_cols;
    logic at_end;
    logic dir_done;
    logic step_ok;
    logic depth_one;
    logic k_last;
    logic slot_free;
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/grid_maze_path_search_top.sv
`default_nettype none

// Depth-first maze solver on a grid of up to MAX_ROWS by MAX_COLS cells (at most 64
// cells), numbered row-major. A wall item steps the lower cell index down by cols until
// it is below cols, which gives its column, and then writes the wall; it returns nothing.
// A solve item tries each direction at a cell in turn and pushes onto the search stack
// where the neighbour is open and not yet visited; a backtrack pops the stack and then
// loads the parent entry (the stack memory read is registered). Each path cell is then
// read from the stack and loaded into the output register, waiting while that register
// holds a result not yet taken. Inputs are taken only while the block is idle; the last
// result may still sit in the output register. Walls are kept per cell index and read
// against the current rows/cols, and register values of 0 or above the maximum are used
// as 1 or the maximum.
module grid_maze_path_search_top import gmps_pkg::*; #(
  parameter int unsigned MAX_ROWS = 8,
  parameter int unsigned MAX_COLS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [DimW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_item_t               out_item_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // configuration must only be written while idle; the block itself does not enforce this
  assign cfg_ready_o = 1'b1;

  gmps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_item_i.func),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gmps_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### hw/rtl/gmps_ctrl.sv
`default_nettype none

module gmps_ctrl import gmps_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_func_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StWallMod,
    StInit,
    StTry,
    StLoad,
    StNoPath,
    StEmitRd,
    StEmitLd
  } state_e;

  state_e state_q, state_d;

  // next state and datapath commands
  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = (in_func_i == FuncSolve) ? StInit : StWallMod;
        end
      end
      StWallMod: begin
        if (status_i.rem_lt_cols) begin
          cmd_o.wall_write = 1'b1;
          state_d = StIdle;
        end else begin
          cmd_o.rem_step = 1'b1;
        end
      end
      StInit: begin
        cmd_o.search_init = 1'b1;
        state_d = StTry;
      end
      StTry: begin
        if (status_i.at_end) begin
          cmd_o.emit_init = 1'b1;
          state_d = StEmitRd;
        end else if (status_i.dir_done) begin
          cmd_o.pop = 1'b1;
          state_d = status_i.depth_one ? StNoPath : StLoad;
        end else if (status_i.step_ok) begin
          cmd_o.push = 1'b1;
        end else begin
          cmd_o.next_dir = 1'b1;
        end
      end
      StLoad: begin
        cmd_o.load_top = 1'b1;
        state_d = StTry;
      end
      StNoPath: begin
        if (status_i.slot_free) begin
          cmd_o.emit_nopath = 1'b1;
          state_d = StIdle;
        end
      end
      StEmitRd: begin
        cmd_o.emit_rd = 1'b1;
        state_d = StEmitLd;
      end
      StEmitLd: begin
        if (status_i.slot_free) begin
          cmd_o.emit_load = 1'b1;
          state_d = status_i.k_last ? StIdle : StEmitRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gmps_dp.sv
`default_nettype none

module gmps_dp import gmps_pkg::*; #(
  parameter int unsigned MAX_ROWS = 8,
  parameter int unsigned MAX_COLS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [DimW-1:0]    cfg_data_i,
  input  wire in_item_t           in_item_i,
  input  wire dp_cmd_t            cmd_i,
  output dp_status_t              status_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output out_item_t               out_item_o
);

  localparam logic [6:0] MaxRows = 7'(MAX_ROWS);
  localparam logic [6:0] MaxCols = 7'(MAX_COLS);

  typedef struct packed {
    logic [CellW-1:0] node;
    logic [DimW-1:0]  row;
    logic [DimW-1:0]  col;
    logic [DirW-1:0]  dir;
  } stack_entry_t;

  logic [DimW-1:0]     rows_cfg_q, cols_cfg_q;
  logic [DimW-1:0]     rows, cols;
  logic [7:0]          total;
  logic [CellW-1:0]    end_cell;

  logic [CellW-1:0]    lo_q, hi_q, rem_q;
  logic [NumCells-1:0] wall_right_q, wall_below_q, visited_q;

  logic [CellW-1:0]    cur_cell_q;
  logic [DimW-1:0]     cur_row_q, cur_col_q;
  logic [DirW-1:0]     cur_dir_q;
  logic [DepthW-1:0]   depth_q;
  logic [DepthW-1:0]   k_q;

  stack_entry_t        stack_mem [NumCells];
  stack_entry_t        rd_q;
  logic [DepthW-1:0]   depth_m1, depth_m2;
  logic [CellW-1:0]    raddr;
  logic                re;

  out_item_t           out_q;
  logic                out_valid_q;

  logic                step_in;
  logic                wall_hit;
  logic [CellW-1:0]    nb_cell;
  logic [DimW-1:0]     nb_row, nb_col;

  logic                wall_ok, is_right, is_below;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= 4'd8;
      cols_cfg_q <= 4'd8;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRowsInUse: rows_cfg_q <= cfg_data_i;
        CfgColsInUse: cols_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp the dimensions in use and derive the end cell
  always_comb begin
    rows = rows_cfg_q;
    if (rows_cfg_q == '0) rows = 4'd1;
    else if ({3'b0, rows_cfg_q} > MaxRows) rows = MaxRows[DimW-1:0];
    cols = cols_cfg_q;
    if (cols_cfg_q == '0) cols = 4'd1;
    else if ({3'b0, cols_cfg_q} > MaxCols) cols = MaxCols[DimW-1:0];
    total    = rows * cols;
    end_cell = CellW'(total - 8'd1);
  end

  // wall placement checks
  assign wall_ok  = ({2'b0, hi_q} < total) && (lo_q != hi_q);
  assign is_right = (({1'b0, lo_q} + 7'd1) == {1'b0, hi_q})
                 && (({1'b0, rem_q} + 7'd1) < {3'b0, cols});
  assign is_below = (({1'b0, lo_q} + {3'b0, cols}) == {1'b0, hi_q});

  // neighbour in the current direction
  always_comb begin
    step_in  = 1'b0;
    wall_hit = 1'b0;
    nb_cell  = cur_cell_q;
    nb_row   = cur_row_q;
    nb_col   = cur_col_q;
    case (cur_dir_q)
      DirUp: begin
        step_in  = (cur_row_q != '0);
        nb_cell  = cur_cell_q - {2'b0, cols};
        nb_row   = cur_row_q - 4'd1;
        wall_hit = wall_below_q[nb_cell];
      end
      DirLeft: begin
        step_in  = (cur_col_q != '0);
        nb_cell  = cur_cell_q - 6'd1;
        nb_col   = cur_col_q - 4'd1;
        wall_hit = wall_right_q[nb_cell];
      end
      DirRight: begin
        step_in  = ({1'b0, cur_col_q} + 5'd1) < {1'b0, cols};
        nb_cell  = cur_cell_q + 6'd1;
        nb_col   = cur_col_q + 4'd1;
        wall_hit = wall_right_q[cur_cell_q];
      end
      DirDown: begin
        step_in  = ({1'b0, cur_row_q} + 5'd1) < {1'b0, rows};
        nb_cell  = cur_cell_q + {2'b0, cols};
        nb_row   = cur_row_q + 4'd1;
        wall_hit = wall_below_q[cur_cell_q];
      end
      default: step_in = 1'b0;
    endcase
  end

  // status to the controller
  assign status_o.rem_lt_cols = ({1'b0, rem_q} < {3'b0, cols});
  assign status_o.at_end      = (cur_cell_q == end_cell);
  assign status_o.dir_done    = (cur_dir_q == DirDone);
  assign status_o.step_ok     = step_in && !wall_hit && !visited_q[nb_cell];
  assign status_o.depth_one   = (depth_q == 7'd1);
  assign status_o.k_last      = (k_q == depth_m1);
  assign status_o.slot_free   = !out_valid_q || out_ready_i;

  // input capture and column of the lower wall cell
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      if (in_item_i.cell_a < in_item_i.cell_b) begin
        lo_q  <= in_item_i.cell_a;
        hi_q  <= in_item_i.cell_b;
        rem_q <= in_item_i.cell_a;
      end else begin
        lo_q  <= in_item_i.cell_b;
        hi_q  <= in_item_i.cell_a;
        rem_q <= in_item_i.cell_b;
      end
    end else if (cmd_i.rem_step) begin
      rem_q <= rem_q - {2'b0, cols};
    end
  end

  // walls and visited marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_right_q <= '0;
      wall_below_q <= '0;
      visited_q    <= '0;
    end else begin
      if (cmd_i.wall_write && wall_ok) begin
        if (is_right) wall_right_q[lo_q] <= 1'b1;
        else if (is_below) wall_below_q[lo_q] <= 1'b1;
      end
      if (cmd_i.search_init) begin
        visited_q    <= '0;
        visited_q[0] <= 1'b1;
      end else if (cmd_i.push) begin
        visited_q[nb_cell] <= 1'b1;
      end
    end
  end

  // top of the search stack and emit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q    <= '0;
      k_q        <= '0;
      cur_cell_q <= '0;
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      cur_dir_q  <= DirUp;
    end else begin
      if (cmd_i.search_init) begin
        depth_q    <= 7'd1;
        cur_cell_q <= '0;
        cur_row_q  <= '0;
        cur_col_q  <= '0;
        cur_dir_q  <= DirUp;
      end else if (cmd_i.push) begin
        depth_q    <= depth_q + 7'd1;
        cur_cell_q <= nb_cell;
        cur_row_q  <= nb_row;
        cur_col_q  <= nb_col;
        cur_dir_q  <= DirUp;
      end else if (cmd_i.next_dir) begin
        cur_dir_q <= cur_dir_q + 3'd1;
      end else if (cmd_i.pop) begin
        depth_q <= depth_m1;
      end else if (cmd_i.load_top) begin
        cur_cell_q <= rd_q.node;
        cur_row_q  <= rd_q.row;
        cur_col_q  <= rd_q.col;
        cur_dir_q  <= rd_q.dir;
      end
      if (cmd_i.emit_init) begin
        k_q <= '0;
      end else if (cmd_i.emit_load) begin
        k_q <= k_q + 7'd1;
      end
    end
  end

  // stack memory, parents below the top entry
  assign depth_m1 = depth_q - 7'd1;
  assign depth_m2 = depth_q - 7'd2;
  assign raddr    = cmd_i.pop ? depth_m2[CellW-1:0] : k_q[CellW-1:0];
  assign re       = cmd_i.pop || cmd_i.emit_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_mem[depth_m1[CellW-1:0]] <= '{node: cur_cell_q, row: cur_row_q,
                                          col: cur_col_q, dir: cur_dir_q + 3'd1};
    end
    if (re) begin
      rd_q <= stack_mem[raddr];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load || cmd_i.emit_nopath) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_nopath) begin
      out_q <= '{path_cell: '0, found: 1'b0, last: 1'b1};
    end else if (cmd_i.emit_load) begin
      out_q.path_cell <= status_o.k_last ? cur_cell_q : rd_q.node;
      out_q.found     <= 1'b1;
      out_q.last      <= status_o.k_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  // stack never holds more cells than have been reached
  a_depth_le_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(depth_q) <= $countones(visited_q))
    else $error("stack deeper than visited set");

  a_depth_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= 7'(NumCells))
    else $error("stack overflow");

  a_push_unvisited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (!visited_q[nb_cell] && step_in))
    else $error("push onto visited or blocked cell");

  a_init_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.search_init |=> (depth_q == 7'd1 && visited_q[0] && $countones(visited_q) == 1))
    else $error("search did not start at cell zero");
`endif

endmodule

`default_nettype wire
